### rtl/core/scd_pkg.sv
package scd_pkg;

  // ASCII codes
  localparam logic [7:0] CH_W    = 8'h57;
  localparam logic [7:0] CH_Q    = 8'h51;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_H    = 8'h48;

  localparam int STICK_W = 16;
  localparam int DIFF_W  = 19;   // stick difference after mirroring
  localparam int PROD_W  = 26;   // difference times gain
  localparam int GAIN_W  = 6;
  localparam int TRIM_W  = 12;
  localparam int OUT_DRIVE_W = 20;
  localparam int ANGLE_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [3:0] EQ_NUDGE = 4'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STICK_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_STEP    = 3'd5;

  // register reset values
  localparam logic [15:0] RST_STICK_CENTER = 16'd128;
  localparam logic [15:0] RST_REVERSE_THR  = 16'd5;
  localparam logic [5:0]  RST_DRIVE_GAIN   = 6'd6;
  localparam logic [15:0] RST_FULL_SPEED   = 16'd1000;
  localparam logic [15:0] RST_TURN_SPEED   = 16'd500;
  localparam logic [11:0] RST_TRIM_STEP    = 12'd50;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MIX,       // carriage return in P mode
    OP_LINK,      // carriage return elsewhere: watchdog only
    OP_FWD,
    OP_REV,
    OP_TURN_C,
    OP_TURN_D,
    OP_TRIM_K,
    OP_TRIM_L,
    OP_EQUAL,
    OP_STOP,
    OP_TARGET,
    OP_PID
  } op_t;

  typedef struct packed {
    logic [15:0]       stick_center;
    logic [15:0]       reverse_threshold;
    logic [GAIN_W-1:0] drive_gain;
    logic [15:0]       full_speed;
    logic [15:0]       turn_speed;
    logic [TRIM_W-1:0] trim_step;
  } cfg_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DIFF_W-1:0]  diff_left;
    logic signed [DIFF_W-1:0]  diff_right;
    logic signed [ANGLE_W-1:0] angle;
  } cmd_t;

  typedef struct packed {
    logic                          drive_valid;
    logic signed [OUT_DRIVE_W-1:0] left_drive;
    logic signed [OUT_DRIVE_W-1:0] right_drive;
    logic                          watchdog_reload;
    logic                          pid_on;
    logic                          target_valid;
    logic signed [ANGLE_W-1:0]     target_angle;
  } res_t;

endpackage

### rtl/core/scd_front.sv
module scd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  input  logic signed [scd_pkg::ANGLE_W-1:0] current_angle,
  input  logic [15:0]                   stick_center,
  input  logic [15:0]                   reverse_threshold,
  input  logic                          q_full,
  output logic                          q_push,
  output scd_pkg::cmd_t                 q_data
);

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_W,
    MODE_Q,
    MODE_P,
    MODE_S
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] first_stick, first_stick_next;
  logic [15:0] second_stick, second_stick_next;

  logic [3:0]         digit;
  logic               is_digit;
  logic signed [16:0] fb, lr;
  logic signed [17:0] lr_m;
  logic               mirror;
  scd_pkg::op_t       op;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign digit    = 4'(rx_byte - scd_pkg::CH_ZERO);
  assign is_digit = (rx_byte >= scd_pkg::CH_ZERO) && (rx_byte <= scd_pkg::CH_NINE);

  // mixing differences, taken from the stick values before this item
  assign fb     = $signed({1'b0, first_stick}) - $signed({1'b0, stick_center});
  assign lr     = $signed({1'b0, second_stick}) - $signed({1'b0, stick_center});
  assign mirror = $signed({fb[16], fb}) > $signed({2'b00, reverse_threshold});
  assign lr_m   = mirror ? -$signed({lr[16], lr}) : $signed({lr[16], lr});

  always_comb begin
    mode_next         = mode;
    first_stick_next  = first_stick;
    second_stick_next = second_stick;
    op                = scd_pkg::OP_NONE;
    priority if (rx_byte == scd_pkg::CH_W) begin
      mode_next = MODE_W;
    end else if (rx_byte == scd_pkg::CH_Q) begin
      mode_next = MODE_Q;
    end else if (rx_byte == scd_pkg::CH_P) begin
      mode_next = MODE_P;
    end else if (rx_byte == scd_pkg::CH_S) begin
      mode_next = MODE_S;
    end else if (is_digit) begin
      // times ten, wrapping at 16 bits
      if (mode == MODE_W || mode == MODE_Q) begin
        first_stick_next = (first_stick << 3) + (first_stick << 1) + {12'd0, digit};
      end else if (mode == MODE_P || mode == MODE_S) begin
        second_stick_next = (second_stick << 3) + (second_stick << 1) + {12'd0, digit};
      end
    end else if (rx_byte == scd_pkg::CH_CR) begin
      op                = (mode == MODE_P) ? scd_pkg::OP_MIX : scd_pkg::OP_LINK;
      first_stick_next  = '0;
      second_stick_next = '0;
    end else if (rx_byte == scd_pkg::CH_A) begin
      op = scd_pkg::OP_FWD;
    end else if (rx_byte == scd_pkg::CH_B) begin
      op = scd_pkg::OP_REV;
    end else if (rx_byte == scd_pkg::CH_C) begin
      op = scd_pkg::OP_TURN_C;
    end else if (rx_byte == scd_pkg::CH_D) begin
      op = scd_pkg::OP_TURN_D;
    end else if (rx_byte == scd_pkg::CH_K) begin
      op = scd_pkg::OP_TRIM_K;
    end else if (rx_byte == scd_pkg::CH_L) begin
      op = scd_pkg::OP_TRIM_L;
    end else if (rx_byte == scd_pkg::CH_E) begin
      op = scd_pkg::OP_EQUAL;
    end else if (rx_byte == scd_pkg::CH_F) begin
      op = scd_pkg::OP_STOP;
    end else if (rx_byte == scd_pkg::CH_G) begin
      op = scd_pkg::OP_TARGET;
    end else if (rx_byte == scd_pkg::CH_H) begin
      op = scd_pkg::OP_PID;
    end else begin
      op = scd_pkg::OP_NONE;
    end
  end

  always_comb begin
    q_data.op         = op;
    q_data.diff_left  = $signed({lr_m[17], lr_m}) - $signed({{2{fb[16]}}, fb});
    q_data.diff_right = -$signed({lr_m[17], lr_m}) - $signed({{2{fb[16]}}, fb});
    q_data.angle      = current_angle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NONE;
      first_stick  <= '0;
      second_stick <= '0;
    end else if (q_push) begin
      mode         <= mode_next;
      first_stick  <= first_stick_next;
      second_stick <= second_stick_next;
    end
  end

endmodule

### rtl/core/scd_fifo.sv
module scd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scd_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output scd_pkg::cmd_t pop_data
);

  scd_pkg::cmd_t mem [2];
  logic          wptr, rptr;
  logic [1:0]    count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/core/scd_back.sv
module scd_back #(
  parameter int DRIVE_BITS = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  scd_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  scd_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output scd_pkg::res_t out_data
);

  localparam int EW = ((DRIVE_BITS > scd_pkg::PROD_W) ? DRIVE_BITS : scd_pkg::PROD_W) + 2;
  localparam logic signed [EW-1:0] SAT_HI =
    {{(EW-DRIVE_BITS+1){1'b0}}, {(DRIVE_BITS-1){1'b1}}};
  localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

  logic signed [DRIVE_BITS-1:0] left_level, right_level;
  logic                         pid_flag, pid_next;

  logic signed [EW-1:0] left_x, right_x, full_x, turn_x, trim_x;
  logic signed [EW-1:0] sum, avg, avg_nudged;
  logic signed [EW-1:0] left_n, right_n;
  logic signed [scd_pkg::PROD_W-1:0] prod_left, prod_right;
  logic signed [scd_pkg::GAIN_W:0]   gain;
  logic signed [DRIVE_BITS-1:0]      left_sat, right_sat;
  logic signed [EW-1:0]              left_sx, right_sx;
  logic                              dv, wd, tv;

  function automatic logic signed [DRIVE_BITS-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[DRIVE_BITS-1:0];
  endfunction

  assign q_pop = q_valid && (!out_valid || out_ready);

  assign left_x  = {{(EW-DRIVE_BITS){left_level[DRIVE_BITS-1]}}, left_level};
  assign right_x = {{(EW-DRIVE_BITS){right_level[DRIVE_BITS-1]}}, right_level};
  assign full_x  = {{(EW-16){1'b0}}, cfg.full_speed};
  assign turn_x  = {{(EW-16){1'b0}}, cfg.turn_speed};
  assign trim_x  = {{(EW-scd_pkg::TRIM_W){1'b0}}, cfg.trim_step};

  assign gain       = $signed({1'b0, cfg.drive_gain});
  assign prod_left  = q_data.diff_left * gain;
  assign prod_right = q_data.diff_right * gain;

  // average truncated toward zero
  assign sum = left_x + right_x;
  assign avg = $signed(sum + {{(EW-1){1'b0}}, sum[EW-1]}) >>> 1;

  always_comb begin
    avg_nudged = avg;
    if (avg > 0) begin
      avg_nudged = avg + {{(EW-4){1'b0}}, scd_pkg::EQ_NUDGE};
    end else if (avg < 0) begin
      avg_nudged = avg - {{(EW-4){1'b0}}, scd_pkg::EQ_NUDGE};
    end
  end

  always_comb begin
    left_n   = left_x;
    right_n  = right_x;
    dv       = 1'b0;
    wd       = 1'b0;
    tv       = 1'b0;
    pid_next = pid_flag;
    unique case (q_data.op)
      scd_pkg::OP_MIX: begin
        left_n  = {{(EW-scd_pkg::PROD_W){prod_left[scd_pkg::PROD_W-1]}}, prod_left};
        right_n = {{(EW-scd_pkg::PROD_W){prod_right[scd_pkg::PROD_W-1]}}, prod_right};
        dv      = 1'b1;
        wd      = 1'b1;
      end
      scd_pkg::OP_LINK: begin
        wd = 1'b1;
      end
      scd_pkg::OP_FWD: begin
        left_n  = full_x;
        right_n = full_x;
        dv      = 1'b1;
        wd      = 1'b1;
      end
      scd_pkg::OP_REV: begin
        left_n  = -full_x;
        right_n = -full_x;
        dv      = 1'b1;
        wd      = 1'b1;
      end
      scd_pkg::OP_TURN_C: begin
        left_n  = left_level[DRIVE_BITS-1] ? -turn_x : turn_x;
        right_n = left_level[DRIVE_BITS-1] ? -full_x : full_x;
        dv      = 1'b1;
        wd      = 1'b1;
      end
      scd_pkg::OP_TURN_D: begin
        left_n  = left_level[DRIVE_BITS-1] ? -full_x : full_x;
        right_n = left_level[DRIVE_BITS-1] ? -turn_x : turn_x;
        dv      = 1'b1;
        wd      = 1'b1;
      end
      scd_pkg::OP_TRIM_K: begin
        left_n  = left_x - trim_x;
        right_n = right_x + trim_x;
        dv      = 1'b1;
      end
      scd_pkg::OP_TRIM_L: begin
        left_n  = left_x + trim_x;
        right_n = right_x - trim_x;
        dv      = 1'b1;
      end
      scd_pkg::OP_EQUAL: begin
        left_n  = avg_nudged;
        right_n = avg;
        dv      = 1'b1;
      end
      scd_pkg::OP_STOP: begin
        left_n  = '0;
        right_n = '0;
        dv      = 1'b1;
      end
      scd_pkg::OP_TARGET: begin
        tv = 1'b1;
      end
      scd_pkg::OP_PID: begin
        pid_next = !pid_flag;
      end
      default: begin
      end
    endcase
  end

  assign left_sat  = sat(left_n);
  assign right_sat = sat(right_n);
  assign left_sx   = {{(EW-DRIVE_BITS){left_sat[DRIVE_BITS-1]}}, left_sat};
  assign right_sx  = {{(EW-DRIVE_BITS){right_sat[DRIVE_BITS-1]}}, right_sat};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data.drive_valid     <= dv;
      out_data.left_drive      <= left_sx[scd_pkg::OUT_DRIVE_W-1:0];
      out_data.right_drive     <= right_sx[scd_pkg::OUT_DRIVE_W-1:0];
      out_data.watchdog_reload <= wd;
      out_data.pid_on          <= pid_next;
      out_data.target_valid    <= tv;
      out_data.target_angle    <= tv ? q_data.angle : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      left_level  <= '0;
      right_level <= '0;
      pid_flag    <= 1'b0;
    end else if (q_pop) begin
      out_valid   <= 1'b1;
      left_level  <= left_sat;
      right_level <= right_sat;
      pid_flag    <= pid_next;
    end else if (out_ready) begin
      out_valid   <= 1'b0;
    end
  end

endmodule

### rtl/core/serial_drive_command_decoder.sv
// Serial drive command decoder. Takes one received byte per item with the
// present heading and returns exactly one result item per byte. Items are
// taken at up to one per clock while the queue is not full: the front
// stage parses mode letters and digits and classifies the byte, a two-entry
// queue carries the command to the back stage, which updates the saturated
// drive pair (one gain multiply per wheel) and registers the result. A
// command passes through the queue and then the output register; the queue
// and output register absorb up to three items while the output side stalls.
// Configuration registers may only be written while no item is in flight.
module serial_drive_command_decoder #(
  parameter int DRIVE_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // rx_byte[7:0], current_angle[39:8]
  input  logic [39:0]                       s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // left_drive[19:0], right_drive[39:20], watchdog_reload[40], pid_on[41],
  // target_angle[73:42], zero[79:74]
  output logic [79:0]                       m_tdata,
  // drive_valid[0], target_valid[1]
  output logic [1:0]                        m_tuser,
  input  logic                              cfg_write,
  input  logic [scd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  scd_pkg::cfg_t cfg;
  scd_pkg::cmd_t push_data, pop_data;
  scd_pkg::res_t res;
  logic          q_full, q_push, q_pop, q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stick_center      <= scd_pkg::RST_STICK_CENTER;
      cfg.reverse_threshold <= scd_pkg::RST_REVERSE_THR;
      cfg.drive_gain        <= scd_pkg::RST_DRIVE_GAIN;
      cfg.full_speed        <= scd_pkg::RST_FULL_SPEED;
      cfg.turn_speed        <= scd_pkg::RST_TURN_SPEED;
      cfg.trim_step         <= scd_pkg::RST_TRIM_STEP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        scd_pkg::REG_STICK_CENTER: cfg.stick_center      <= cfg_data;
        scd_pkg::REG_REVERSE_THR:  cfg.reverse_threshold <= cfg_data;
        scd_pkg::REG_DRIVE_GAIN:   cfg.drive_gain        <= cfg_data[scd_pkg::GAIN_W-1:0];
        scd_pkg::REG_FULL_SPEED:   cfg.full_speed        <= cfg_data;
        scd_pkg::REG_TURN_SPEED:   cfg.turn_speed        <= cfg_data;
        scd_pkg::REG_TRIM_STEP:    cfg.trim_step         <= cfg_data[scd_pkg::TRIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  scd_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .rx_byte           (s_tdata[7:0]),
    .current_angle     (s_tdata[39:8]),
    .stick_center      (cfg.stick_center),
    .reverse_threshold (cfg.reverse_threshold),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (push_data)
  );

  scd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (pop_data)
  );

  scd_back #(
    .DRIVE_BITS (DRIVE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {6'd0, res.target_angle, res.pid_on, res.watchdog_reload,
                    res.right_drive, res.left_drive};
  assign m_tuser = {res.target_valid, res.drive_valid};

endmodule

### rtl/core/scd_checker.sv
module scd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result item shown right after reset");

  // angle is zero unless a target was captured
  a_angle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> (m_tdata[73:42] == 32'd0))
    else $error("target angle nonzero without target capture");

  // a heading capture never issues drive or reloads the watchdog
  a_target_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && !m_tdata[40])
    else $error("target capture mixed with drive command");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result item changed");

endmodule

bind serial_drive_command_decoder scd_checker u_scd_checker (.*);
